// ===== sv/oqkr_pkg.sv =====
// Shared types and constants for the ordered tag queue with keyed removal.
// Used by the top level, the tag store and the port checker.
package oqkr_pkg;

    // Default geometry of the queue.
    localparam int DEPTH_DEF = 16;
    localparam int TAG_W_DEF = 32;

    // Fixed widths of the port fields.
    localparam int CMD_W     = 3;
    localparam int TAG_OUT_W = 32;
    localparam int OCC_W     = 5;

    // Command codes carried by each input word.
    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ    = 3'd0,
        CMD_DEQ    = 3'd1,
        CMD_PEEK   = 3'd2,
        CMD_NEXT   = 3'd3,
        CMD_REMOVE = 3'd4
    } cmd_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_NEXT_RD,
        ST_NEXT_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_DONE
    } state_t;

    // Control from the sequencer to the tag store.
    typedef struct packed {
        logic wr_en;     // write one cell this cycle
        logic wr_shift;  // write data comes from the last read (gap closing)
    } store_ctl_t;

endpackage

// ===== sv/oqkr_store.sv =====
// Tag store: single-port-write, registered-read memory of queue cells plus
// the one shared tag comparator. Depends on oqkr_pkg.
module oqkr_store #(
    parameter int DEPTH  = oqkr_pkg::DEPTH_DEF,
    parameter int TAG_W  = oqkr_pkg::TAG_W_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  oqkr_pkg::store_ctl_t ctl,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  logic [ADDR_W-1:0]   rd_addr,
    input  logic [TAG_W-1:0]    tag_wr,
    input  logic [TAG_W-1:0]    key,
    output logic [TAG_W-1:0]    rd_data,
    output logic                hit
);
    import oqkr_pkg::*;

    logic [TAG_W-1:0] mem [DEPTH];
    logic [TAG_W-1:0] rd_data_reg;
    logic [TAG_W-1:0] wr_data;

    // Write data is either a new tag or the cell just read, moved down one place.
    assign wr_data = ctl.wr_shift ? rd_data_reg : tag_wr;

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Shared comparator against the search key.
    assign rd_data = rd_data_reg;
    assign hit     = (rd_data_reg == key);

endmodule

// ===== sv/ordered_queue_with_keyed_removal_top.sv =====
// Ordered tag queue with keyed search and removal, one command per word; up to DEPTH entries held.
// Enqueue, unused codes and any command on an empty queue go straight to the result; peek reads
// the head cell; dequeue reads the head and, like a remove hit, closes the gap by shifting the
// later cells down; next-after scans for the key and on a hit reads the cell behind it, if any;
// remove scans for the key. One word at a time; in_ready rises with out_valid, and a result still waiting
// holds the next command in its last state. Reset (rst_n low, asynchronous) empties the queue.
module ordered_queue_with_keyed_removal_top #(
    parameter int DEPTH = oqkr_pkg::DEPTH_DEF,
    parameter int TAG_W = oqkr_pkg::TAG_W_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [oqkr_pkg::CMD_W-1:0]      command,
    input  logic [31:0]                     tag_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            found,
    output logic [oqkr_pkg::TAG_OUT_W-1:0]  tag_out,
    output logic                            full_refused,
    output logic [oqkr_pkg::OCC_W-1:0]      occupancy
);
    import oqkr_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    state_t             state_reg, state_next;
    cmd_t               op_reg, op_next;
    logic [TAG_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               found_reg, found_next;
    logic [TAG_W-1:0]   res_tag_reg, res_tag_next;
    logic               refused_reg, refused_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg, out_found_next;
    logic [TAG_W-1:0]   out_tag_reg, out_tag_next;
    logic               out_refused_reg, out_refused_next;
    logic [CNT_W-1:0]   out_count_reg, out_count_next;

    logic [TAG_W-1:0]   tag_in_w;
    logic [CNT_W-1:0]   idx_inc;
    logic               accept;
    logic               out_free;
    logic               is_full;
    logic               is_empty;
    store_ctl_t         ctl;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [TAG_W-1:0]   rd_data;
    logic               hit;

    // Fit the 32-bit tag field to the stored tag width, and back.
    generate
        if (TAG_W >= TAG_OUT_W)
        begin : g_tag_wide
            assign tag_in_w = TAG_W'(tag_in);
            assign tag_out  = out_tag_reg[TAG_OUT_W-1:0];
        end
        else
        begin : g_tag_narrow
            assign tag_in_w = tag_in[TAG_W-1:0];
            assign tag_out  = {{(TAG_OUT_W - TAG_W){1'b0}}, out_tag_reg};
        end
    endgenerate

    // Fit the count to the occupancy field.
    generate
        if (CNT_W >= OCC_W)
        begin : g_occ_wide
            assign occupancy = out_count_reg[OCC_W-1:0];
        end
        else
        begin : g_occ_narrow
            assign occupancy = {{(OCC_W - CNT_W){1'b0}}, out_count_reg};
        end
    endgenerate

    assign in_ready     = (state_reg == ST_IDLE);
    assign accept       = in_valid && in_ready;
    assign out_free     = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign found        = out_found_reg;
    assign full_refused = out_refused_reg;
    assign idx_inc      = idx_reg + 1'b1;
    assign is_full      = (count_reg == CNT_W'(DEPTH));
    assign is_empty     = (count_reg == '0);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_t'(command))
                        CMD_DEQ, CMD_PEEK, CMD_NEXT, CMD_REMOVE:
                            state_next = is_empty ? ST_DONE : ST_RD;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_RD:
                state_next = ST_CMP;
            ST_CMP:
            begin
                case (op_reg)
                    CMD_PEEK:
                        state_next = ST_DONE;
                    CMD_DEQ:
                        state_next = ST_SH_RD;
                    CMD_NEXT:
                    begin
                        if (hit)
                            state_next = (idx_inc < count_reg) ? ST_NEXT_RD : ST_DONE;
                        else
                            state_next = (idx_inc < count_reg) ? ST_RD : ST_DONE;
                    end
                    CMD_REMOVE:
                    begin
                        if (hit)
                            state_next = ST_SH_RD;
                        else
                            state_next = (idx_inc < count_reg) ? ST_RD : ST_DONE;
                    end
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_NEXT_RD:
                state_next = ST_NEXT_CMP;
            ST_NEXT_CMP:
                state_next = ST_DONE;
            ST_SH_RD:
                state_next = (idx_inc < count_reg) ? ST_SH_WR : ST_DONE;
            ST_SH_WR:
                state_next = ST_SH_RD;
            ST_DONE:
                state_next = out_free ? ST_IDLE : ST_DONE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control for each state.
    always_comb
    begin
        op_next          = op_reg;
        key_next         = key_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        found_next       = found_reg;
        res_tag_next     = res_tag_reg;
        refused_next     = refused_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_found_next   = out_found_reg;
        out_tag_next     = out_tag_reg;
        out_refused_next = out_refused_reg;
        out_count_next   = out_count_reg;
        ctl.wr_en        = 1'b0;
        ctl.wr_shift     = 1'b0;
        wr_addr          = idx_reg[ADDR_W-1:0];
        rd_addr          = idx_reg[ADDR_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next      = cmd_t'(command);
                    key_next     = tag_in_w;
                    idx_next     = '0;
                    found_next   = 1'b0;
                    res_tag_next = '0;
                    refused_next = 1'b0;
                    // Enqueue finishes here: append at the tail or refuse.
                    if (cmd_t'(command) == CMD_ENQ)
                    begin
                        if (is_full)
                        begin
                            refused_next = 1'b1;
                        end
                        else
                        begin
                            ctl.wr_en    = 1'b1;
                            wr_addr      = count_reg[ADDR_W-1:0];
                            count_next   = count_reg + 1'b1;
                            found_next   = 1'b1;
                            res_tag_next = tag_in_w;
                        end
                    end
                end
            end
            ST_CMP:
            begin
                case (op_reg)
                    CMD_PEEK, CMD_DEQ:
                    begin
                        found_next   = 1'b1;
                        res_tag_next = rd_data;
                    end
                    CMD_NEXT:
                    begin
                        idx_next = idx_inc;
                    end
                    CMD_REMOVE:
                    begin
                        if (hit)
                        begin
                            found_next   = 1'b1;
                            res_tag_next = key_reg;
                        end
                        else
                        begin
                            idx_next = idx_inc;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_NEXT_CMP:
            begin
                found_next   = 1'b1;
                res_tag_next = rd_data;
            end
            ST_SH_RD:
            begin
                // Read the cell above the gap, or finish with one entry fewer.
                rd_addr = idx_inc[ADDR_W-1:0];
                if (!(idx_inc < count_reg))
                    count_next = count_reg - 1'b1;
            end
            ST_SH_WR:
            begin
                ctl.wr_en    = 1'b1;
                ctl.wr_shift = 1'b1;
                idx_next     = idx_inc;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_found_next   = found_reg;
                    out_tag_next     = res_tag_reg;
                    out_refused_next = refused_reg;
                    out_count_next   = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        key_reg         <= key_next;
        idx_reg         <= idx_next;
        found_reg       <= found_next;
        res_tag_reg     <= res_tag_next;
        refused_reg     <= refused_next;
        out_found_reg   <= out_found_next;
        out_tag_reg     <= out_tag_next;
        out_refused_reg <= out_refused_next;
        out_count_reg   <= out_count_next;
    end

    // Queue cells and the shared comparator.
    oqkr_store #(
        .DEPTH  (DEPTH),
        .TAG_W  (TAG_W),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .ctl     (ctl),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .tag_wr  (key_next),
        .key     (key_reg),
        .rd_data (rd_data),
        .hit     (hit)
    );

endmodule

// ===== sv/oqkr_checker.sv =====
// Port-level checks for the ordered tag queue, bound to the top level.
// Depends on oqkr_pkg and the top level's ports.
module oqkr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            found,
    input logic [oqkr_pkg::TAG_OUT_W-1:0]  tag_out,
    input logic                            full_refused,
    input logic [oqkr_pkg::OCC_W-1:0]      occupancy
);
    import oqkr_pkg::*;

    // A refused enqueue never reports success.
    a_refused_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(found && full_refused))
        else $error("refused enqueue reported as found");

    // A failed command returns a zero tag.
    a_miss_zero_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (tag_out == '0))
        else $error("tag_out not zero on a failed command");

    // The block works on one word at a time: it stalls the next cycle after taking one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a command is still in progress");

    // A stalled result holds its fields.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(tag_out)
            && $stable(found) && $stable(occupancy) && $stable(full_refused)))
        else $error("result changed while stalled");

endmodule

bind ordered_queue_with_keyed_removal_top oqkr_checker u_oqkr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .tag_out      (tag_out),
    .full_refused (full_refused),
    .occupancy    (occupancy)
);
